// ----- sv/signed_int_to_decimal_padded_assert.svh -----
// Assertion helpers used by the RTL file sitdp_back.sv.
`ifndef SIGNED_INT_TO_DECIMAL_PADDED_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_PADDED_ASSERT_SVH

// Checked only while out of reset.
`define SITDP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define SITDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sitdp_pkg.sv -----
`default_nettype none
package sitdp_pkg;

    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_MINUS = 6'd45;
    localparam logic [5:0] CH_SPACE = 6'd32;

    // shift-add-3 bits handled per cycle
    localparam int BITS_PER_STEP = 4;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage
`default_nettype wire

// ----- sv/sitdp_front.sv -----
`default_nettype none
module sitdp_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire sitdp_pkg::fifo_status_t q_status,
    output logic                       q_push,
    output logic                       q_neg,
    output logic [VALUE_BITS-1:0]      q_mag
);

    logic                  valid_reg;
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_w;

    assign q_push   = valid_reg && !q_status.full;
    assign in_ready = !valid_reg || !q_status.full;
    assign q_neg    = neg_reg;
    assign q_mag    = mag_reg;
    assign neg_w    = in_value[VALUE_BITS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (q_push) begin
            valid_reg <= 1'b0;
        end
    end

    // magnitude held unsigned, so the most negative value stays exact
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            neg_reg <= neg_w;
            mag_reg <= neg_w ? (~in_value + VALUE_BITS'(1)) : in_value;
        end
    end

endmodule
`default_nettype wire

// ----- sv/sitdp_fifo.sv -----
`default_nettype none
module sitdp_fifo #(
    parameter int WIDTH = 33
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        pop_data,
    output sitdp_pkg::fifo_status_t status
);

    localparam int DEPTH = sitdp_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/sitdp_back.sv -----
`default_nettype none
`include "signed_int_to_decimal_padded_assert.svh"
module sitdp_back #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire sitdp_pkg::fifo_status_t q_status,
    input  wire logic                    in_neg,
    input  wire logic [VALUE_BITS-1:0]   in_mag,
    output logic                         in_pop,
    input  wire logic [5:0]              min_width,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast
);

    localparam int BPS    = sitdp_pkg::BITS_PER_STEP;
    localparam int STEPS  = (VALUE_BITS + BPS - 1) / BPS;
    localparam int MAGW   = STEPS * BPS;
    localparam int STW    = $clog2(STEPS + 1);
    // 0.31 > log10(2), so this bounds the digits of 2^(VALUE_BITS-1)
    localparam int NDIG   = (VALUE_BITS * 31) / 100 + 1;
    localparam int DIGW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int TOTMAX = (MAX_WIDTH > NDIG + 1) ? MAX_WIDTH : NDIG + 1;
    localparam int CNTW   = $clog2(TOTMAX + 1);

    sitdp_pkg::back_state_t state_reg, state_next;

    logic                  neg_reg, neg_next;
    logic [MAGW-1:0]       shift_reg, shift_next;
    logic [NDIG*4-1:0]     bcd_reg, bcd_next;
    logic [STW-1:0]        step_reg, step_next;
    logic [CNTW-1:0]       text_len_reg, text_len_next;
    logic [CNTW-1:0]       rem_reg, rem_next;

    logic [3:0]            digit_w [NDIG];
    logic [NDIG*4-1:0]     dab_bcd;
    logic [MAGW-1:0]       dab_shift;
    logic [CNTW-1:0]       ndig_w;
    logic [CNTW-1:0]       text_len_w;
    logic [CNTW-1:0]       width_w;
    logic [6:0]            width_sat;
    logic [CNTW-1:0]       rem_m1;
    logic [5:0]            char_w;

    for (genvar g = 0; g < NDIG; g++) begin : g_dig
        assign digit_w[g] = bcd_reg[g*4 +: 4];
    end

    // shift-add-3, BPS bits per cycle
    always_comb begin
        dab_bcd   = bcd_reg;
        dab_shift = shift_reg;
        for (int st = 0; st < BPS; st++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (dab_bcd[d*4 +: 4] >= 4'd5) begin
                    dab_bcd[d*4 +: 4] = dab_bcd[d*4 +: 4] + 4'd3;
                end
            end
            {dab_bcd, dab_shift} = {dab_bcd, dab_shift} << 1;
        end
    end

    // significant digits, at least one
    always_comb begin
        ndig_w = CNTW'(1);
        for (int i = 1; i < NDIG; i++) begin
            if (digit_w[i] != 4'd0) begin
                ndig_w = CNTW'(i + 1);
            end
        end
    end

    assign text_len_w = ndig_w + CNTW'(neg_reg);
    assign width_sat  = ({1'b0, min_width} > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH)
                                                            : {1'b0, min_width};
    assign width_w    = CNTW'(width_sat);
    assign rem_m1     = rem_reg - CNTW'(1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sitdp_pkg::ST_IDLE: begin
                if (!q_status.empty) begin
                    state_next = sitdp_pkg::ST_CONV;
                end
            end
            sitdp_pkg::ST_CONV: begin
                if (step_reg == STW'(1)) begin
                    state_next = sitdp_pkg::ST_COUNT;
                end
            end
            sitdp_pkg::ST_COUNT: begin
                state_next = sitdp_pkg::ST_EMIT;
            end
            sitdp_pkg::ST_EMIT: begin
                if (m_tready && rem_reg == CNTW'(1)) begin
                    state_next = sitdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sitdp_pkg::ST_IDLE;
            end
        endcase
    end

    // characters count down: pad, then sign, then digits high to low
    always_comb begin
        if (rem_reg > text_len_reg) begin
            char_w = sitdp_pkg::CH_SPACE;
        end else if (neg_reg && rem_reg == text_len_reg) begin
            char_w = sitdp_pkg::CH_MINUS;
        end else begin
            char_w = sitdp_pkg::CH_ZERO + {2'b00, digit_w[rem_m1[DIGW-1:0]]};
        end
    end

    always_comb begin
        in_pop   = (state_reg == sitdp_pkg::ST_IDLE) && !q_status.empty;
        m_tvalid = (state_reg == sitdp_pkg::ST_EMIT);
        m_tlast  = (rem_reg == CNTW'(1));
        m_tdata  = {2'b00, char_w};
    end

    always_comb begin
        neg_next      = neg_reg;
        shift_next    = shift_reg;
        bcd_next      = bcd_reg;
        step_next     = step_reg;
        text_len_next = text_len_reg;
        rem_next      = rem_reg;
        case (state_reg)
            sitdp_pkg::ST_IDLE: begin
                neg_next   = in_neg;
                shift_next = MAGW'(in_mag);
                bcd_next   = '0;
                step_next  = STW'(STEPS);
            end
            sitdp_pkg::ST_CONV: begin
                bcd_next   = dab_bcd;
                shift_next = dab_shift;
                step_next  = step_reg - STW'(1);
            end
            sitdp_pkg::ST_COUNT: begin
                text_len_next = text_len_w;
                rem_next      = (text_len_w > width_w) ? text_len_w : width_w;
            end
            sitdp_pkg::ST_EMIT: begin
                if (m_tready) begin
                    rem_next = rem_m1;
                end
            end
            default: begin
                rem_next = rem_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sitdp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        step_reg     <= step_next;
        text_len_reg <= text_len_next;
        rem_reg      <= rem_next;
    end

    `SITDP_ASSERT_CLK(a_emit_nonzero, aclk, aresetn, m_tvalid |-> rem_reg != '0, "emit with no chars left")
    `SITDP_ASSERT_CLK(a_last_ends, aclk, aresetn, (m_tvalid && m_tready && m_tlast) |=> !m_tvalid, "output continued past last char")
    `SITDP_ASSERT_CLK(a_count_fits, aclk, aresetn, (state_reg == sitdp_pkg::ST_COUNT) |=> (rem_reg >= text_len_reg && text_len_reg != '0), "field narrower than text")
    `SITDP_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
`default_nettype wire

// ----- sv/signed_int_to_decimal_padded.sv -----
// Converts each signed integer request into its decimal ASCII text, one character per
// output request, most significant first, with a leading '-' for negatives (the most
// negative value included) and spaces on the left up to min_width characters
// (min_width above MAX_WIDTH counts as MAX_WIDTH; zero means no padding). m_tlast marks
// the final character; no terminator follows. The back end loads an item from the
// two-entry queue, runs it through its shift-add-3 converter, counts the digits, then
// emits the max(text length, min(min_width, MAX_WIDTH)) characters of the field. The
// front register and queue accept up to three further items meanwhile. min_width is
// written by cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, which the block does not enforce; reset value 8.
`default_nettype none
module signed_int_to_decimal_padded #(
    parameter int MAX_WIDTH  = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [5:0]                   cfg_wr_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,  // [VALUE_BITS-1:0] value
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata,  // [5:0] char_code
    output logic                              m_tlast
);

    localparam int QW = VALUE_BITS + 1;

    logic [5:0]              min_width_reg;
    sitdp_pkg::fifo_status_t q_status;
    logic                    q_push;
    logic                    q_pop;
    logic                    f_neg;
    logic [VALUE_BITS-1:0]   f_mag;
    logic [QW-1:0]           q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg <= 6'd8;
        end else if (cfg_wr_en) begin
            min_width_reg <= cfg_wr_data;
        end
    end

    sitdp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_value(s_tdata[VALUE_BITS-1:0]),
        .q_status(q_status),
        .q_push  (q_push),
        .q_neg   (f_neg),
        .q_mag   (f_mag)
    );

    sitdp_fifo #(
        .WIDTH(QW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({f_neg, f_mag}),
        .pop      (q_pop),
        .pop_data (q_out),
        .status   (q_status)
    );

    sitdp_back #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .in_neg   (q_out[QW-1]),
        .in_mag   (q_out[VALUE_BITS-1:0]),
        .in_pop   (q_pop),
        .min_width(min_width_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- tb/decimal_text_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module decimal_text_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               chars_pending,
    output int               values_seen,
    output int               negatives_seen,
    output int               chars_seen
);

    localparam int FIELD_CAP = 32;
    localparam logic [31:0] RADIX = 32'd10;

    typedef struct packed {
        logic [5:0] code;
        logic       last;
    } text_char_t;

    text_char_t  expected_text[$];
    logic [5:0]  field_width;

    initial begin
        fail_count     = 0;
        chars_pending  = 0;
        values_seen    = 0;
        negatives_seen = 0;
        chars_seen     = 0;
        field_width    = 6'd8;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Builds the padded decimal text of one value and queues it.
    task automatic predict_text(input logic [31:0] value);
        logic       neg;
        logic [31:0] mag;
        logic [3:0] digs [0:9];
        int         ndig;
        int         text_len;
        int         width;
        int         total;
        int         k;
        text_char_t ch;
        neg  = value[31];
        mag  = neg ? (~value + 32'd1) : value;
        ndig = 0;
        do begin
            digs[ndig] = 4'(mag % RADIX);
            mag = mag / RADIX;
            ndig++;
        end while (mag != 0);
        text_len = ndig + (neg ? 1 : 0);
        width    = (int'(field_width) > FIELD_CAP) ? FIELD_CAP : int'(field_width);
        total    = (text_len > width) ? text_len : width;
        ch.last  = 1'b0;
        for (k = 0; k < total - text_len; k++) begin
            ch.code = sitdp_pkg::CH_SPACE;
            expected_text.push_back(ch);
        end
        if (neg) begin
            ch.code = sitdp_pkg::CH_MINUS;
            expected_text.push_back(ch);
        end
        for (k = ndig; k > 0; k--) begin
            ch.code = sitdp_pkg::CH_ZERO + 6'(digs[k-1]);
            expected_text.push_back(ch);
        end
        expected_text[expected_text.size()-1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            field_width = 6'd8;
            expected_text.delete();
        end else begin
            if (cfg_wr_en)
                field_width = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                chars_seen++;
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("char %0d with no request pending",
                                              m_tdata[5:0]));
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata[5:0] !== want.code)
                        report_mismatch($sformatf("char_code got %0d want %0d",
                                                  m_tdata[5:0], want.code));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_char got %b want %b",
                                                  m_tlast, want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                values_seen++;
                if (s_tdata[31])
                    negatives_seen++;
                predict_text(s_tdata);
            end
        end
        chars_pending = expected_text.size();
    end
endmodule
`default_nettype wire

// ----- tb/tb_signed_int_to_decimal_padded.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_signed_int_to_decimal_padded;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = 6'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;   // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [5:0] char_code
    logic        m_tlast;

    logic        steady = 1'b0;     // no gaps on either side
    int          rx_hold = 0;
    int          rx_wait;
    int          idle_cycles = 0;
    int          width_settings = 1;

    int fail_count, chars_pending, values_seen, negatives_seen, chars_seen;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    signed_int_to_decimal_padded dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    decimal_text_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .chars_pending  (chars_pending),
        .values_seen    (values_seen),
        .negatives_seen (negatives_seen),
        .chars_seen     (chars_seen)
    );

    // Receiver: randomly stalls after each character, unless steady is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            rx_wait = steady ? 0 : $urandom_range(0, 3);
            rx_hold  <= rx_wait;
            m_tready <= (rx_wait == 0);
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL signed_int_to_decimal_padded");
            $finish;
        end
    end

    // Mostly values of a random digit count, some fully random words.
    function automatic logic [31:0] random_value();
        int          ndig;
        logic [31:0] mag;
        logic [31:0] lo;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        ndig = $urandom_range(1, 10);
        lo = 32'd1;
        repeat (ndig - 1) lo = lo * 32'd10;
        if (ndig == 10)
            mag = $urandom_range(32'd1_000_000_000, 32'd2_147_483_647);
        else
            mag = $urandom_range(ndig == 1 ? 0 : lo, lo * 32'd10 - 32'd1);
        return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_value(input logic [31:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (chars_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] directed [] = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, 32'd99, 32'd100,
            32'd12345678, -32'sd1234567, 32'd123456789, INT_MAX, INT_MIN,
            32'h8000_0001, 32'd1_000_000_000, -32'sd1_000_000_000,
            32'h5555_5555, 32'hAAAA_AAAA
        };
        int width_plan [] = '{0, 32, 63, 1, 33, 11, 12, 8, 0};
        width_plan[8] = $urandom_range(0, 63);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset width of 8 first
        foreach (directed[i])
            send_value(directed[i]);
        repeat (7) send_value(random_value());
        drain();

        foreach (width_plan[p]) begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= 6'(width_plan[p]);
            steady      <= ($urandom_range(0, 3) == 0);
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            width_settings++;
            send_value(32'd0);
            send_value(INT_MIN);
            send_value(INT_MAX);
            send_value(32'hFFFF_FFFF);
            repeat (5) send_value(random_value());
            drain();
        end

        $display("Converted %0d values (%0d negative) into %0d checked characters",
                 values_seen, negatives_seen, chars_seen);
        $display("across %0d field-width settings, 0 and 63 among them", width_settings);
        if (fail_count == 0)
            $display("PASS signed_int_to_decimal_padded");
        else
            $display("FAIL signed_int_to_decimal_padded");
        $finish;
    end
endmodule
`default_nettype wire
